FILE: rtl/core/three_axis_moving_average_change_detect_core_macros.svh
// Assertion macros shared by the moving average core and its sub-modules.
// Each file that asserts includes this header; no other dependencies.
`ifndef THREE_AXIS_MOVING_AVERAGE_CHANGE_DETECT_CORE_MACROS_SVH
`define THREE_AXIS_MOVING_AVERAGE_CHANGE_DETECT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TAMACD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`define TAMACD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define TAMACD_ASSERT_NEXT(lbl, ante, cons, msg)
`define TAMACD_ASSERT_NOW(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/tamacd_pkg.sv
// Shared types and constants of the three-axis moving average core.
// No dependencies; the lane and the top level of the core import this package.
package tamacd_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int THR_W       = 16;
    localparam int AXES        = 3;
    localparam int WINDOW_DEF  = 10;
    localparam int TDATA_W     = AXES * SAMPLE_W;
    localparam int TUSER_W     = 1;

    localparam logic [THR_W-1:0] THR_RESET = 16'd8192;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic en;
        logic acc;
        logic a_vld;
        logic old_vld;
        logic d_vld;
    } t_lane_ctl;

endpackage

FILE: rtl/core/tamacd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-axis sample windows; no dependencies.
module tamacd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/tamacd_lane.sv
// One axis lane: sample window, running sum, divide by the window length
// and change compare. Depends on tamacd_pkg, tamacd_ram and the macro header.
`include "three_axis_moving_average_change_detect_core_macros.svh"
module tamacd_lane #(
    parameter int WINDOW = tamacd_pkg::WINDOW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tamacd_pkg::t_lane_ctl             i_ctl,
    input  logic [$clog2(WINDOW)-1:0]         i_raddr,
    input  logic [$clog2(WINDOW)-1:0]         i_waddr,
    input  tamacd_pkg::t_sample               i_sample,
    input  logic [tamacd_pkg::THR_W-1:0]      i_thr,
    output tamacd_pkg::t_sample               o_mean,
    output logic                              o_exceed
);
    import tamacd_pkg::*;

    localparam int AW     = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_W + AW;
    localparam int SHIFT  = SUM_W + AW;
    localparam int PROD_W = 2 * SUM_W + 1;
    localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'(((64'd1 << SHIFT) + WINDOW - 1) / WINDOW);

    t_sample                   r_smp;
    logic [SAMPLE_W-1:0]       rd_old;
    logic signed [SUM_W-1:0]   old_ext;
    logic signed [SUM_W-1:0]   smp_ext;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [SUM_W-1:0]   n_sum;
    logic [SUM_W-1:0]          mag;
    logic [PROD_W-1:0]         prod;
    logic [PROD_W-1:0]         r_prod;
    logic                      r_neg;
    logic [SAMPLE_W-1:0]       quo;
    t_sample                   r_mean;
    t_sample                   r_prev;
    logic signed [SAMPLE_W:0]  diff;
    logic [SAMPLE_W:0]         absd;

    tamacd_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(WINDOW)
    ) u_win (
        .i_clk   (i_clk),
        .i_we    (i_ctl.en && i_ctl.a_vld),
        .i_waddr (i_waddr),
        .i_wdata (r_smp),
        .i_re    (i_ctl.acc),
        .i_raddr (i_raddr),
        .o_rdata (rd_old)
    );

    always_comb begin
        old_ext = i_ctl.old_vld ? {{AW{rd_old[SAMPLE_W-1]}}, rd_old} : '0;
        smp_ext = {{AW{r_smp[SAMPLE_W-1]}}, r_smp};
        n_sum   = r_sum - old_ext + smp_ext;
        mag     = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
        prod    = {{(SUM_W + 1){1'b0}}, mag} * {{SUM_W{1'b0}}, RECIP};
        quo     = r_prod[SHIFT +: SAMPLE_W];
        diff    = {r_mean[SAMPLE_W-1], r_mean} - {r_prev[SAMPLE_W-1], r_prev};
        absd    = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_smp  <= i_sample;
            r_prod <= prod;
            r_neg  <= r_sum[SUM_W-1];
            r_mean <= r_neg ? (~quo + 1'b1) : quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_prev <= '0;
        end else if (i_ctl.en) begin
            if (i_ctl.a_vld) begin
                r_sum <= n_sum;
            end
            if (i_ctl.d_vld) begin
                r_prev <= r_mean;
            end
        end
    end

    assign o_mean   = r_mean;
    assign o_exceed = absd > {1'b0, i_thr};

    `TAMACD_ASSERT_NEXT(a_prev_follows_mean, i_ctl.en && i_ctl.d_vld, r_prev == $past(r_mean), "previous mean not updated from the finished item")
    `TAMACD_ASSERT_NEXT(a_sum_holds, !(i_ctl.en && i_ctl.a_vld), $stable(r_sum), "running sum changed without an item")
    `TAMACD_ASSERT_NOW(a_exceed_zero_diff, r_mean == r_prev, !o_exceed, "change flagged with equal means")

endmodule

FILE: rtl/core/three_axis_moving_average_change_detect_core.sv
// Top level of the three-axis moving average core: control, lanes and merge stage.
// Depends on tamacd_pkg, tamacd_lane, tamacd_ram and the macro header.
//
// Usage:
// The input stream carries one item per accelerometer sample with X, Y and Z
// packed in i_s_axis_tdata. Each accepted item yields exactly one result item
// with the three window averages in o_m_axis_tdata and the change flag in
// o_m_axis_tuser. The averages cover the last WINDOW items, with the window
// holding zeros after reset, and are truncated toward zero.
// The change threshold is written through the cfg channel, which is always
// ready; it resets to 8192 and should be written only while the core is idle.
// An accepted item passes stages A, B, C and D and then the output register.
// Throughput is one item per cycle; the pipeline runs on one shared enable, so
// every stage, including the running sum, advances in the same cycle.
// When the receiver stalls, the whole pipeline holds and o_s_axis_tready drops
// until the output register is taken; up to five items are in flight.
// Reset clears the windows through per-entry valid bits, the running sums,
// the previous averages and the ring position.
`include "three_axis_moving_average_change_detect_core_macros.svh"
module three_axis_moving_average_change_detect_core #(
    parameter int WINDOW = tamacd_pkg::WINDOW_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // sample_x, sample_y, sample_z
    input  logic [tamacd_pkg::TDATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // mean_x, mean_y, mean_z
    output logic [tamacd_pkg::TDATA_W-1:0]   o_m_axis_tdata,
    // changed
    output logic [tamacd_pkg::TUSER_W-1:0]   o_m_axis_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tamacd_pkg::THR_W-1:0]     i_cfg_data
);
    import tamacd_pkg::*;

    localparam int AW = $clog2(WINDOW);
    localparam logic [AW-1:0] SLOT_LAST = AW'(WINDOW - 1);

    logic                 en;
    logic                 acc;
    t_lane_ctl            ctl;
    logic [AW-1:0]        r_slot;
    logic [AW-1:0]        r_a_slot;
    logic [WINDOW-1:0]    r_written;
    logic                 r_a_vld;
    logic                 r_a_old;
    logic                 r_b_vld;
    logic                 r_c_vld;
    logic                 r_d_vld;
    logic                 r_out_valid;
    logic [TDATA_W-1:0]   r_out_data;
    logic                 r_out_changed;
    logic [THR_W-1:0]     r_thr;
    t_sample              mean [AXES];
    logic [AXES-1:0]      exceed;

    assign en  = !r_out_valid || i_m_axis_tready;
    assign acc = i_s_axis_tvalid && en;

    always_comb begin
        ctl.en      = en;
        ctl.acc     = acc;
        ctl.a_vld   = r_a_vld;
        ctl.old_vld = r_a_old;
        ctl.d_vld   = r_d_vld;
    end

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        tamacd_lane #(
            .WINDOW(WINDOW)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_raddr  (r_slot),
            .i_waddr  (r_a_slot),
            .i_sample (i_s_axis_tdata[a*SAMPLE_W +: SAMPLE_W]),
            .i_thr    (r_thr),
            .o_mean   (mean[a]),
            .o_exceed (exceed[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_slot <= r_slot;
            r_a_old  <= r_written[r_slot];
            for (int a = 0; a < AXES; a++) begin
                r_out_data[a*SAMPLE_W +: SAMPLE_W] <= mean[a];
            end
            r_out_changed <= |exceed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_written   <= '0;
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_c_vld     <= 1'b0;
            r_d_vld     <= 1'b0;
            r_out_valid <= 1'b0;
            r_thr       <= THR_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (acc) begin
                r_slot            <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
                r_written[r_slot] <= 1'b1;
            end
            if (en) begin
                r_a_vld     <= acc;
                r_b_vld     <= r_a_vld;
                r_c_vld     <= r_b_vld;
                r_d_vld     <= r_c_vld;
                r_out_valid <= r_d_vld;
            end
        end
    end

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_changed;
    assign o_cfg_ready     = 1'b1;

    `TAMACD_ASSERT_NEXT(a_acc_enters_pipe, acc, r_a_vld, "accepted item did not enter the pipeline")
    `TAMACD_ASSERT_NEXT(a_stall_holds_slot, !en, $stable(r_slot) && r_out_valid, "ring position moved during a stall")
    `TAMACD_ASSERT_NOW(a_slot_in_range, 1'b1, r_slot <= SLOT_LAST, "ring position beyond the window")
    `TAMACD_ASSERT_NEXT(a_last_stage_to_out, en && r_d_vld, r_out_valid, "finished item did not reach the output")

endmodule

FILE: tb/tb_three_axis_moving_average_change_detect_core.sv
// Self-checking testbench for the three-axis moving average core with change flag.
// It predicts every window average and change flag and compares each result item.
// Depends on tamacd_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb_three_axis_moving_average_change_detect_core;
    import tamacd_pkg::*;

    localparam int WINDOW = WINDOW_DEF;
    localparam t_sample S_MAX = 16'sh7fff;
    localparam t_sample S_MIN = 16'sh8000;

    typedef struct packed {
        t_sample z;
        t_sample y;
        t_sample x;
    } axis_triple_t;

    typedef struct packed {
        axis_triple_t means;
        logic         changed;
    } mean_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic [TDATA_W-1:0]   s_data = '0;
    logic                 m_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [THR_W-1:0]     cfg_data = '0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [TDATA_W-1:0]   o_m_axis_tdata;
    logic [TUSER_W-1:0]   o_m_axis_tuser;
    logic                 o_cfg_ready;

    axis_triple_t pending_samples[$];
    mean_result_t expected_means[$];

    t_sample      win_buf [AXES][WINDOW];
    int           axis_sum [AXES];
    int           prev_mean [AXES];
    int           ring_pos = 0;
    logic [THR_W-1:0] change_thr = THR_RESET;
    int           level [AXES];

    int send_idle_pct = 18;
    int recv_idle_pct = 61;
    int rx_hold_req = 0;
    int rx_hold_served = 0;
    int rx_hold_left = 0;
    int mismatch_count = 0;

    three_axis_moving_average_change_detect_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Advances the window model by one sample and stores the expected result.
    task automatic update_window_average(input axis_triple_t smp);
        t_sample      samples [AXES];
        t_sample      means [AXES];
        mean_result_t res;
        int           mean_v;
        int           delta;
        samples[0] = smp.x;
        samples[1] = smp.y;
        samples[2] = smp.z;
        res.changed = 1'b0;
        for (int a = 0; a < AXES; a++) begin
            axis_sum[a] = axis_sum[a] - int'(win_buf[a][ring_pos]) + int'(samples[a]);
            win_buf[a][ring_pos] = samples[a];
            mean_v = axis_sum[a] / WINDOW;
            delta = mean_v - prev_mean[a];
            if (delta < 0) begin
                delta = -delta;
            end
            if (delta > int'(change_thr)) begin
                res.changed = 1'b1;
            end
            prev_mean[a] = mean_v;
            means[a] = t_sample'(mean_v);
        end
        ring_pos = (ring_pos == WINDOW - 1) ? 0 : ring_pos + 1;
        res.means.x = means[0];
        res.means.y = means[1];
        res.means.z = means[2];
        expected_means.push_back(res);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                update_window_average(axis_triple_t'(s_data));
            end
            if (!s_valid || o_s_axis_tready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data <= pending_samples.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold_req != rx_hold_served) begin
            rx_hold_served <= rx_hold_req;
            rx_hold_left <= 100;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        mean_result_t exp_r;
        axis_triple_t got;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && m_ready) begin
                got = axis_triple_t'(o_m_axis_tdata);
                if (expected_means.size() == 0) begin
                    $display("%0t: result item with none expected, actual %h/%b", $realtime,
                             o_m_axis_tdata, o_m_axis_tuser);
                    mismatch_count++;
                end else begin
                    exp_r = expected_means.pop_front();
                    if (got.x !== exp_r.means.x) begin
                        $display("%0t: mean_x expected %0d actual %0d", $realtime,
                                 exp_r.means.x, got.x);
                        mismatch_count++;
                    end
                    if (got.y !== exp_r.means.y) begin
                        $display("%0t: mean_y expected %0d actual %0d", $realtime,
                                 exp_r.means.y, got.y);
                        mismatch_count++;
                    end
                    if (got.z !== exp_r.means.z) begin
                        $display("%0t: mean_z expected %0d actual %0d", $realtime,
                                 exp_r.means.z, got.z);
                        mismatch_count++;
                    end
                    if (o_m_axis_tuser[0] !== exp_r.changed) begin
                        $display("%0t: changed expected %b actual %b", $realtime,
                                 exp_r.changed, o_m_axis_tuser[0]);
                        mismatch_count++;
                    end
                end
            end
            m_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_sample extreme_sample();
        case ($urandom_range(3))
            0: return S_MAX;
            1: return S_MIN;
            2: return t_sample'(0);
            default: return t_sample'(-1);
        endcase
    endfunction

    task automatic push_triple(input t_sample x, input t_sample y, input t_sample z, input int n);
        axis_triple_t smp;
        smp.x = x;
        smp.y = y;
        smp.z = z;
        repeat (n) pending_samples.push_back(smp);
    endtask

    // Mixes full-range noise, steady levels with small jitter and sudden steps,
    // and full-scale, zero and minus-one values.
    task automatic queue_random_items(input int n);
        int           kind;
        t_sample      vals [AXES];
        axis_triple_t smp;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(9);
            for (int a = 0; a < AXES; a++) begin
                if (kind < 4) begin
                    vals[a] = t_sample'($urandom());
                end else if (kind < 8) begin
                    if ($urandom_range(11) == 0) begin
                        level[a] = int'($urandom_range(60000)) - 30000;
                    end
                    vals[a] = t_sample'(level[a] + int'($urandom_range(64)) - 32);
                end else begin
                    vals[a] = extreme_sample();
                end
            end
            smp.x = vals[0];
            smp.y = vals[1];
            smp.z = vals[2];
            pending_samples.push_back(smp);
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || s_valid || expected_means.size() != 0);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        change_thr = value;
    endtask

    initial begin
        for (int a = 0; a < AXES; a++) begin
            axis_sum[a] = 0;
            prev_mean[a] = 0;
            level[a] = 0;
            for (int k = 0; k < WINDOW; k++) begin
                win_buf[a][k] = '0;
            end
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Start-up ramp from an all-zero window, full-scale plateaus and a wrap
        // of the ring, under the reset threshold.
        push_triple(t_sample'(0), t_sample'(0), t_sample'(0), 1);
        push_triple(S_MAX, S_MIN, t_sample'(1), 11);
        push_triple(S_MIN, S_MAX, t_sample'(-1), 10);
        push_triple(t_sample'(16384), t_sample'(-16384), t_sample'(0), 2);
        wait_drained();

        write_threshold('0);
        queue_random_items(150);
        wait_drained();

        send_idle_pct = 61;
        recv_idle_pct = 18;
        write_threshold(16'hffff);
        queue_random_items(120);
        wait_drained();

        write_threshold(16'd1000);
        queue_random_items(150);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(16'($urandom_range(3000)));
        rx_hold_req = rx_hold_req + 1;
        queue_random_items(130);
        wait_drained();

        write_threshold(16'd6553);
        queue_random_items(80);
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (expected_means.size() != 0) begin
            $display("%0t: %0d expected result items never arrived", $realtime,
                     expected_means.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout", $realtime);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/tamacd_pkg.sv
rtl/core/tamacd_ram.sv
rtl/core/tamacd_lane.sv
rtl/core/three_axis_moving_average_change_detect_core.sv
tb/tb_three_axis_moving_average_change_detect_core.sv
